// ----- rtl/cmap_pkg.sv -----
// Shared constants, types and codes for the colormap lookup pipeline.
// Used by cmap_divider, colormap_index_to_rgb and cmap_checker.
package cmap_pkg;

    localparam int MAX_ENTRIES = 4096;
    localparam int COLOR_MAX   = 255;

    localparam int IDX_W  = 12;                  // entry_index
    localparam int SIZE_W = 13;                  // table_size
    localparam int CH_W   = 8;                   // one colour channel
    localparam int RN_W   = 13;                  // ramp numerator / denominator
    localparam int PW     = 28;                  // ratio numerator / denominator
    localparam int DIV_STEPS = 9;                // quotient bits, top one saturates
    localparam int RW     = PW + DIV_STEPS;      // dividend and remainder
    localparam int CFG_IDX_W = 2;

    // register levels from input transfer to result register
    localparam int LAT = 3 + DIV_STEPS + 1;

    localparam logic [IDX_W-1:0]  MIN_SIZE  = IDX_W'(2);
    localparam logic [SIZE_W-1:0] MAX_SIZE  = SIZE_W'(MAX_ENTRIES);
    localparam logic [SIZE_W-1:0] RESET_SIZE = SIZE_W'(256);

    localparam logic [14:0] COPPER_K_R = 15'd12500;
    localparam logic [14:0] COPPER_K_G = 15'd7812;
    localparam logic [14:0] COPPER_K_B = 15'd4975;
    localparam logic [13:0] COPPER_DEN = 14'd10000;

    typedef enum logic [2:0] {
        MAP_SPRING = 3'd0,
        MAP_SUMMER = 3'd1,
        MAP_AUTUMN = 3'd2,
        MAP_WINTER = 3'd3,
        MAP_HOT    = 3'd4,
        MAP_BONE   = 3'd5,
        MAP_COPPER = 3'd6,
        MAP_COOL   = 3'd7
    } map_t;

    localparam logic [CFG_IDX_W-1:0] REG_MAP_SELECT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_TABLE_SIZE = CFG_IDX_W'(1);

    // channel value is floor(COLOR_MAX * num / den), capped at full scale
    typedef struct packed {
        logic [PW-1:0] num;
        logic [PW-1:0] den;
    } ratio_t;

endpackage

// ----- rtl/colormap_index_to_rgb.sv -----
// Top level of the pseudo-colour lookup: config registers, ramp and ratio stages,
// three channel dividers. Depends on cmap_pkg and cmap_divider.

// Takes one entry_index per clock and returns red, green and blue for the map in
// map_select over a table of table_size entries (clamped to 2..4096; the index is
// clamped to the last entry). Every item passes through the pipeline in order:
// clamp, ramp selection, ratio products, the scaled dividend, then a nine-stage
// restoring divider per channel, one quotient bit a stage. The whole pipeline
// holds when a result is stalled at the output; otherwise a new transfer is taken
// every cycle. Configuration writes are always accepted and take effect on items
// that arrive after them.
module colormap_index_to_rgb (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [cmap_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cmap_pkg::SIZE_W-1:0]    cfg_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [cmap_pkg::IDX_W-1:0]     s_entry_index,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [cmap_pkg::CH_W-1:0]      m_red,
    output logic [cmap_pkg::CH_W-1:0]      m_green,
    output logic [cmap_pkg::CH_W-1:0]      m_blue
);

    cmap_pkg::map_t              map_reg;
    logic [cmap_pkg::SIZE_W-1:0] size_reg;

    logic                        vld_reg [0:cmap_pkg::LAT-1];
    logic                        adv;

    // clamped table geometry
    logic [cmap_pkg::SIZE_W-1:0] len_c;
    logic [cmap_pkg::IDX_W-1:0]  m_c;
    logic [cmap_pkg::IDX_W-1:0]  i_c;
    logic [cmap_pkg::SIZE_W+1:0] len3;

    // stage A
    cmap_pkg::map_t              map_a_reg;
    logic [cmap_pkg::SIZE_W-1:0] len_a_reg;
    logic [cmap_pkg::IDX_W-1:0]  m_a_reg;
    logic [cmap_pkg::IDX_W-1:0]  i_a_reg;
    logic [cmap_pkg::SIZE_W-1:0] n_a_reg;

    // stage B
    cmap_pkg::map_t              map_b_reg;
    logic [cmap_pkg::IDX_W-1:0]  m_b_reg;
    logic [cmap_pkg::IDX_W-1:0]  i_b_reg;
    logic [cmap_pkg::RN_W-1:0]   rp_reg [0:2];
    logic [cmap_pkg::RN_W-1:0]   rq_reg [0:2];
    logic [cmap_pkg::RN_W-1:0]   rp_next [0:2];
    logic [cmap_pkg::RN_W-1:0]   rq_next [0:2];

    // stage C
    cmap_pkg::ratio_t            red_reg, green_reg, blue_reg;
    cmap_pkg::ratio_t            red_next, green_next, blue_next;
    cmap_pkg::ratio_t            bone_r [0:2];

    assign adv       = !vld_reg[cmap_pkg::LAT-1] || m_ready;
    assign s_ready   = adv;
    assign cfg_ready = 1'b1;
    assign m_valid   = vld_reg[cmap_pkg::LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_reg  <= cmap_pkg::MAP_SPRING;
            size_reg <= cmap_pkg::RESET_SIZE;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                cmap_pkg::REG_MAP_SELECT: map_reg  <= cmap_pkg::map_t'(cfg_data[2:0]);
                cmap_pkg::REG_TABLE_SIZE: size_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (size_reg < cmap_pkg::SIZE_W'(cmap_pkg::MIN_SIZE)) begin
            len_c = cmap_pkg::SIZE_W'(cmap_pkg::MIN_SIZE);
        end else if (size_reg > cmap_pkg::MAX_SIZE) begin
            len_c = cmap_pkg::MAX_SIZE;
        end else begin
            len_c = size_reg;
        end
        m_c  = cmap_pkg::IDX_W'(len_c - 1'b1);
        i_c  = (s_entry_index > m_c) ? m_c : s_entry_index;
        len3 = ((cmap_pkg::SIZE_W+2)'(len_c) << 1) + (cmap_pkg::SIZE_W+2)'(len_c);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < cmap_pkg::LAT; k++) vld_reg[k] <= 1'b0;
        end else if (adv) begin
            vld_reg[0] <= s_valid;
            for (int k = 1; k < cmap_pkg::LAT; k++) vld_reg[k] <= vld_reg[k-1];
        end
    end

    // stage A: clamp and table geometry
    always_ff @(posedge aclk) begin
        if (adv) begin
            map_a_reg <= map_reg;
            len_a_reg <= len_c;
            m_a_reg   <= m_c;
            i_a_reg   <= i_c;
            n_a_reg   <= cmap_pkg::SIZE_W'(len3 >> 3);
        end
    end

    // stage B: hot-style ramps, break points at n and 2n
    always_comb begin
        logic [cmap_pkg::SIZE_W:0] i1, n1, n2, len1;
        i1   = (cmap_pkg::SIZE_W+1)'(i_a_reg) + 1'b1;
        n1   = (cmap_pkg::SIZE_W+1)'(n_a_reg);
        n2   = n1 << 1;
        len1 = (cmap_pkg::SIZE_W+1)'(len_a_reg);
        if ((cmap_pkg::SIZE_W+1)'(i_a_reg) < n1) begin
            rp_next[0] = cmap_pkg::RN_W'(i1);
            rq_next[0] = cmap_pkg::RN_W'(n1);
        end else begin
            rp_next[0] = cmap_pkg::RN_W'(1);
            rq_next[0] = cmap_pkg::RN_W'(1);
        end
        if ((cmap_pkg::SIZE_W+1)'(i_a_reg) < n1) begin
            rp_next[1] = '0;
            rq_next[1] = cmap_pkg::RN_W'(1);
        end else if ((cmap_pkg::SIZE_W+1)'(i_a_reg) < n2) begin
            rp_next[1] = cmap_pkg::RN_W'(i1 - n1);
            rq_next[1] = cmap_pkg::RN_W'(n1);
        end else begin
            rp_next[1] = cmap_pkg::RN_W'(1);
            rq_next[1] = cmap_pkg::RN_W'(1);
        end
        if ((cmap_pkg::SIZE_W+1)'(i_a_reg) < n2) begin
            rp_next[2] = '0;
            rq_next[2] = cmap_pkg::RN_W'(1);
        end else begin
            rp_next[2] = cmap_pkg::RN_W'(i1 - n2);
            rq_next[2] = cmap_pkg::RN_W'(len1 - n2);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            map_b_reg <= map_a_reg;
            m_b_reg   <= m_a_reg;
            i_b_reg   <= i_a_reg;
            for (int k = 0; k < 3; k++) begin
                rp_reg[k] <= rp_next[k];
                rq_reg[k] <= rq_next[k];
            end
        end
    end

    // stage C: per-map ratios; bone is (7*i*q + p*m) / (8*q*m)
    for (genvar s = 0; s < 3; s++) begin : g_bone
        logic [cmap_pkg::PW-1:0] iq, pm, qm;
        assign iq = cmap_pkg::PW'(i_b_reg) * cmap_pkg::PW'(rq_reg[s]);
        assign pm = cmap_pkg::PW'(rp_reg[s]) * cmap_pkg::PW'(m_b_reg);
        assign qm = cmap_pkg::PW'(rq_reg[s]) * cmap_pkg::PW'(m_b_reg);
        assign bone_r[s].num = (iq << 3) - iq + pm;
        assign bone_r[s].den = qm << 3;
    end

    always_comb begin
        logic [cmap_pkg::PW-1:0] pi, pm_, pmi, p2m, pcu;
        pi   = cmap_pkg::PW'(i_b_reg);
        pm_  = cmap_pkg::PW'(m_b_reg);
        pmi  = pm_ - pi;
        p2m  = pm_ << 1;
        pcu  = pm_ * cmap_pkg::PW'(cmap_pkg::COPPER_DEN);
        red_next   = '{num: cmap_pkg::PW'(1), den: cmap_pkg::PW'(1)};
        green_next = '{num: pi, den: pm_};
        blue_next  = '{num: pmi, den: pm_};
        unique case (map_b_reg)
            cmap_pkg::MAP_SPRING: ;
            cmap_pkg::MAP_SUMMER: begin
                red_next   = '{num: pi, den: pm_};
                green_next = '{num: pm_ + pi, den: p2m};
                blue_next  = '{num: cmap_pkg::PW'(2), den: cmap_pkg::PW'(5)};
            end
            cmap_pkg::MAP_AUTUMN: begin
                blue_next  = '{num: '0, den: cmap_pkg::PW'(1)};
            end
            cmap_pkg::MAP_WINTER: begin
                red_next   = '{num: '0, den: cmap_pkg::PW'(1)};
                blue_next  = '{num: p2m - pi, den: p2m};
            end
            cmap_pkg::MAP_HOT: begin
                red_next   = '{num: cmap_pkg::PW'(rp_reg[0]), den: cmap_pkg::PW'(rq_reg[0])};
                green_next = '{num: cmap_pkg::PW'(rp_reg[1]), den: cmap_pkg::PW'(rq_reg[1])};
                blue_next  = '{num: cmap_pkg::PW'(rp_reg[2]), den: cmap_pkg::PW'(rq_reg[2])};
            end
            cmap_pkg::MAP_BONE: begin
                red_next   = bone_r[2];
                green_next = bone_r[1];
                blue_next  = bone_r[0];
            end
            cmap_pkg::MAP_COPPER: begin
                red_next   = '{num: pi * cmap_pkg::PW'(cmap_pkg::COPPER_K_R), den: pcu};
                green_next = '{num: pi * cmap_pkg::PW'(cmap_pkg::COPPER_K_G), den: pcu};
                blue_next  = '{num: pi * cmap_pkg::PW'(cmap_pkg::COPPER_K_B), den: pcu};
            end
            cmap_pkg::MAP_COOL: begin
                red_next   = '{num: pi, den: pm_};
                green_next = '{num: pmi, den: pm_};
                blue_next  = '{num: cmap_pkg::PW'(1), den: cmap_pkg::PW'(1)};
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    cmap_divider u_div_red (
        .aclk  (aclk),
        .adv   (adv),
        .ratio (red_reg),
        .chan  (m_red)
    );

    cmap_divider u_div_green (
        .aclk  (aclk),
        .adv   (adv),
        .ratio (green_reg),
        .chan  (m_green)
    );

    cmap_divider u_div_blue (
        .aclk  (aclk),
        .adv   (adv),
        .ratio (blue_reg),
        .chan  (m_blue)
    );

endmodule

// ----- rtl/cmap_divider.sv -----
// Pipelined restoring divider: one quotient bit per stage, saturating at 255.
// Depends on cmap_pkg for widths and the ratio type.
module cmap_divider (
    input  logic                    aclk,
    input  logic                    adv,
    input  cmap_pkg::ratio_t        ratio,
    output logic [cmap_pkg::CH_W-1:0] chan
);

    logic [cmap_pkg::RW-1:0]        rem_reg [0:cmap_pkg::DIV_STEPS];
    logic [cmap_pkg::PW-1:0]        den_reg [0:cmap_pkg::DIV_STEPS];
    logic [cmap_pkg::DIV_STEPS-1:0] quo_reg [0:cmap_pkg::DIV_STEPS];

    logic [cmap_pkg::RW-1:0]        rem_next [0:cmap_pkg::DIV_STEPS-1];
    logic [cmap_pkg::DIV_STEPS-1:0] quo_next [0:cmap_pkg::DIV_STEPS-1];
    logic [cmap_pkg::RW-1:0]        dividend;

    // COLOR_MAX * num
    assign dividend = cmap_pkg::RW'(ratio.num) * cmap_pkg::RW'(cmap_pkg::COLOR_MAX);

    for (genvar k = 0; k < cmap_pkg::DIV_STEPS; k++) begin : g_step
        logic [cmap_pkg::RW-1:0] trial;
        logic                    ge;
        assign trial = cmap_pkg::RW'(den_reg[k]) << (cmap_pkg::DIV_STEPS - 1 - k);
        assign ge    = (rem_reg[k] >= trial);
        always_comb begin
            rem_next[k] = ge ? (rem_reg[k] - trial) : rem_reg[k];
            quo_next[k] = quo_reg[k];
            quo_next[k][cmap_pkg::DIV_STEPS-1-k] = ge;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            rem_reg[0] <= dividend;
            den_reg[0] <= ratio.den;
            quo_reg[0] <= '0;
            for (int k = 0; k < cmap_pkg::DIV_STEPS; k++) begin
                rem_reg[k+1] <= rem_next[k];
                den_reg[k+1] <= den_reg[k];
                quo_reg[k+1] <= quo_next[k];
            end
        end
    end

    assign chan = quo_reg[cmap_pkg::DIV_STEPS][cmap_pkg::DIV_STEPS-1]
                ? {cmap_pkg::CH_W{1'b1}}
                : quo_reg[cmap_pkg::DIV_STEPS][cmap_pkg::CH_W-1:0];

endmodule

// ----- rtl/cmap_checker.sv -----
// Port-level checks for colormap_index_to_rgb, attached by the bind below.
// Depends on cmap_pkg for port widths.
module cmap_port_checks (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           cfg_valid,
    input logic                           cfg_ready,
    input logic [cmap_pkg::CFG_IDX_W-1:0] cfg_index,
    input logic [cmap_pkg::SIZE_W-1:0]    cfg_data,
    input logic                           s_valid,
    input logic                           s_ready,
    input logic [cmap_pkg::IDX_W-1:0]     s_entry_index,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic [cmap_pkg::CH_W-1:0]      m_red,
    input logic [cmap_pkg::CH_W-1:0]      m_green,
    input logic [cmap_pkg::CH_W-1:0]      m_blue
);

    // hold a stalled result
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_red) && $stable(m_green) && $stable(m_blue))
        else $error("result changed while stalled");

    // an empty output stage never blocks the input side
    a_no_block: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

    a_stall_prop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("transfer taken while output stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result present after reset");

endmodule

bind colormap_index_to_rgb cmap_port_checks u_cmap_port_checks (.*);
